[sv/ybf_pkg.sv]
// Shared constants, command and status types, and the CRC step for the YMODEM block framer.
`timescale 1ns / 1ps

package ybf_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int LONG_BLOCK  = 1024;
  localparam int SHORT_BLOCK = 128;

  localparam int SIZE_W = 21;
  localparam int OFF_W  = $clog2(LONG_BLOCK);
  localparam int BN_W   = 11;

  localparam logic [OFF_W-1:0] LONG_LAST  = OFF_W'(LONG_BLOCK - 1);
  localparam logic [OFF_W-1:0] SHORT_LAST = OFF_W'(SHORT_BLOCK - 1);
  localparam logic [SIZE_W-1:0] LONG_SIZE = SIZE_W'(LONG_BLOCK);
  localparam logic [BN_W-1:0] BN_LIMIT    = BN_W'(MAX_BLOCKS);

  localparam logic [7:0] SOH_OCTET = 8'h01;
  localparam logic [7:0] STX_OCTET = 8'h02;
  localparam logic [7:0] PAD_OCTET = 8'h1A;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_IDLE_DATA = 2'd2;

  // Source of the byte sent in one datapath step
  typedef enum logic [2:0] {
    SRC_HDR_TYPE,
    SRC_HDR_NUM,
    SRC_HDR_INV,
    SRC_DATA,
    SRC_PAD,
    SRC_CRC_HI,
    SRC_CRC_LO,
    SRC_SUM
  } ybf_src_t;

  typedef struct packed {
    logic     load;        // start beat: load file size
    logic     idle_data;   // data beat while idle: empty result, status 2
    logic     start_item;  // data beat while busy: latch byte, open block if needed
    logic     emit;        // send one byte this cycle
    ybf_src_t src;         // which byte
    logic     last;        // this byte closes the run
  } ybf_cmd_t;

  typedef struct packed {
    logic busy;
    logic block_start;
    logic rem_one;
    logic off_last;
    logic use_crc;
    logic out_free;
  } ybf_stat_t;

  // One byte through CRC-16/XMODEM, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[sv/ybf_datapath.sv]
// Datapath: transfer state, CRC and sum, byte packer and output register.
`timescale 1ns / 1ps

module ybf_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  ybf_pkg::ybf_cmd_t         cmd,
  output ybf_pkg::ybf_stat_t        stat,
  input  logic [ybf_pkg::SIZE_W-1:0] file_size,
  input  logic [7:0]                data_octet,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                first_octet,
  output logic [7:0]                second_octet,
  output logic [7:0]                third_octet,
  output logic [7:0]                fourth_octet,
  output logic [2:0]                octet_count,
  output logic                      block_end,
  output logic                      transfer_end,
  output logic [1:0]                status,
  output logic                      last_of_run
);
  import ybf_pkg::*;

  logic              use_crc;
  logic [SIZE_W-1:0] remaining;
  logic [OFF_W-1:0]  offset;
  logic              long_flag;
  logic [BN_W-1:0]   block_number;
  logic [15:0]       crc;
  logic [7:0]        sum;
  logic              busy;
  logic [7:0]        data_reg;
  logic [7:0]        pk_b [3];
  logic [1:0]        pk_cnt;

  logic [7:0] emit_byte;
  logic       absorb;
  logic       close;
  logic       rem_zero;
  logic       limit_hit;
  logic       push;
  logic [7:0] w [4];
  logic [2:0] w_cnt;
  logic       w_blk_end;
  logic       w_xfer_end;
  logic [1:0] w_status;
  logic       w_last;

  // Select the byte for this step
  always_comb begin
    unique case (cmd.src)
      SRC_HDR_TYPE: emit_byte = long_flag ? STX_OCTET : SOH_OCTET;
      SRC_HDR_NUM:  emit_byte = block_number[7:0];
      SRC_HDR_INV:  emit_byte = ~block_number[7:0];
      SRC_DATA:     emit_byte = data_reg;
      SRC_PAD:      emit_byte = PAD_OCTET;
      SRC_CRC_HI:   emit_byte = crc[15:8];
      SRC_CRC_LO:   emit_byte = crc[7:0];
      SRC_SUM:      emit_byte = sum;
      default:      emit_byte = 8'h00;
    endcase
  end

  assign absorb    = cmd.emit && (cmd.src == SRC_DATA || cmd.src == SRC_PAD);
  assign close     = cmd.emit && cmd.last && (cmd.src == SRC_CRC_LO || cmd.src == SRC_SUM);
  assign rem_zero  = (remaining == '0);
  assign limit_hit = (block_number >= BN_LIMIT);
  assign push      = (cmd.emit && (cmd.last || pk_cnt == 2'd3)) ||
                     (cmd.load && file_size == '0) || cmd.idle_data;

  // Assemble the result word: packed bytes plus this step's byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i] = 8'h00;
    end
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < pk_cnt) begin
        w[i] = pk_b[i];
      end
    end
    if (cmd.emit) begin
      w[pk_cnt] = emit_byte;
    end
    w_cnt      = cmd.emit ? (3'(pk_cnt) + 3'd1) : 3'd0;
    w_last     = cmd.emit ? cmd.last : 1'b1;
    w_blk_end  = close;
    w_xfer_end = cmd.load || (close && (rem_zero || limit_hit));
    if (cmd.idle_data) begin
      w_status = ST_IDLE_DATA;
    end else if (close && !rem_zero && limit_hit) begin
      w_status = ST_LIMIT;
    end else begin
      w_status = ST_OK;
    end
  end

  // Transfer state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      use_crc      <= 1'b1;
      remaining    <= '0;
      offset       <= '0;
      long_flag    <= 1'b0;
      block_number <= BN_W'(1);
      crc          <= '0;
      sum          <= '0;
      busy         <= 1'b0;
      pk_cnt       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        use_crc <= cfg_wdata;
      end
      // Arm or drop a transfer
      if (cmd.load) begin
        remaining    <= file_size;
        offset       <= '0;
        long_flag    <= 1'b0;
        block_number <= BN_W'(1);
        crc          <= '0;
        sum          <= '0;
        busy         <= (file_size != '0);
      end
      // Open a new block on its first data byte
      if (cmd.start_item && offset == '0) begin
        long_flag <= (remaining >= LONG_SIZE);
        crc       <= '0;
        sum       <= '0;
      end
      if (absorb) begin
        crc    <= crc_update(crc, emit_byte);
        sum    <= sum + emit_byte;
        offset <= offset + OFF_W'(1);
      end
      if (cmd.emit && cmd.src == SRC_DATA) begin
        remaining <= remaining - SIZE_W'(1);
      end
      // Close the block after its check bytes
      if (close) begin
        offset <= '0;
        if (rem_zero || limit_hit) begin
          busy <= 1'b0;
        end else begin
          block_number <= block_number + BN_W'(1);
        end
      end
      // Packer fill count
      if (push) begin
        pk_cnt <= '0;
      end else if (cmd.emit) begin
        pk_cnt <= pk_cnt + 2'd1;
      end
      // Output register handshake
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start_item) begin
      data_reg <= data_octet;
    end
    if (cmd.emit && !push) begin
      pk_b[pk_cnt] <= emit_byte;
    end
    if (push) begin
      first_octet  <= w[0];
      second_octet <= w[1];
      third_octet  <= w[2];
      fourth_octet <= w[3];
      octet_count  <= w_cnt;
      block_end    <= w_blk_end;
      transfer_end <= w_xfer_end;
      status       <= w_status;
      last_of_run  <= w_last;
    end
  end

  assign stat.busy        = busy;
  assign stat.block_start = (offset == '0);
  assign stat.rem_one     = (remaining == SIZE_W'(1));
  assign stat.off_last    = (offset == (long_flag ? LONG_LAST : SHORT_LAST));
  assign stat.use_crc     = use_crc;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

[sv/ybf_ctrl.sv]
// Controller: sequences header, data, padding and check bytes for each input beat.
`timescale 1ns / 1ps

module ybf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  ybf_pkg::ybf_stat_t stat,
  output ybf_pkg::ybf_cmd_t  cmd
);
  import ybf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_DATA,
    S_PAD,
    S_CHK,
    S_CHK_LO
  } state_t;

  localparam logic [1:0] HDR_LAST = 2'd2;

  state_t     state, state_next;
  logic [1:0] hdr_idx, hdr_idx_next;

  assign in_ready = (state == S_IDLE) && stat.out_free;

  // Next state and commands
  always_comb begin
    state_next     = state;
    hdr_idx_next   = hdr_idx;
    cmd            = '0;
    cmd.src        = SRC_DATA;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (!mode) begin
            cmd.load = 1'b1;
          end else if (!stat.busy) begin
            cmd.idle_data = 1'b1;
          end else begin
            cmd.start_item = 1'b1;
            hdr_idx_next   = '0;
            state_next     = stat.block_start ? S_HDR : S_DATA;
          end
        end
      end
      S_HDR: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          priority if (hdr_idx == 2'd0) begin
            cmd.src = SRC_HDR_TYPE;
          end else if (hdr_idx == 2'd1) begin
            cmd.src = SRC_HDR_NUM;
          end else begin
            cmd.src = SRC_HDR_INV;
          end
          hdr_idx_next = hdr_idx + 2'd1;
          if (hdr_idx == HDR_LAST) begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_DATA;
          if (stat.rem_one) begin
            state_next = stat.off_last ? S_CHK : S_PAD;
          end else if (stat.off_last) begin
            state_next = S_CHK;
          end else begin
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_PAD: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_PAD;
          if (stat.off_last) begin
            state_next = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.use_crc) begin
            cmd.src    = SRC_CRC_HI;
            state_next = S_CHK_LO;
          end else begin
            cmd.src    = SRC_SUM;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_CHK_LO: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_CRC_LO;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and header index
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      hdr_idx <= '0;
    end else begin
      state   <= state_next;
      hdr_idx <= hdr_idx_next;
    end
  end

endmodule

[sv/ymodem_block_framer.sv]
// Top level of the YMODEM block framer: controller plus datapath.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   mode, file_size, data_octet
//   out      output     out_valid / out_ready first..fourth_octet, octet_count,
//                                             block_end, transfer_end, status,
//                                             last_of_run
//   cfg      input      cfg_we                cfg_wdata (use_crc)
//
// A start beat or a data beat while idle is handled when it is accepted. A data beat
// inside a block is accepted and its byte sent, after the three header bytes where a
// block opens, and followed at a block end by any pad bytes and the one or two check bytes.
// The controller sends one output byte per cycle while the output is free; four bytes fill a result.
// Synchronous reset returns to idle with CRC mode on and block number one.
// A stalled output holds the byte sequencer and keeps in_ready low.
`timescale 1ns / 1ps

module ymodem_block_framer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [ybf_pkg::SIZE_W-1:0] file_size,
  input  logic [7:0]                 data_octet,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 first_octet,
  output logic [7:0]                 second_octet,
  output logic [7:0]                 third_octet,
  output logic [7:0]                 fourth_octet,
  output logic [2:0]                 octet_count,
  output logic                       block_end,
  output logic                       transfer_end,
  output logic [1:0]                 status,
  output logic                       last_of_run
);
  import ybf_pkg::*;

  ybf_cmd_t  cmd;
  ybf_stat_t stat;

  ybf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  ybf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .file_size    (file_size),
    .data_octet   (data_octet),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_octet  (first_octet),
    .second_octet (second_octet),
    .third_octet  (third_octet),
    .fourth_octet (fourth_octet),
    .octet_count  (octet_count),
    .block_end    (block_end),
    .transfer_end (transfer_end),
    .status       (status),
    .last_of_run  (last_of_run)
  );

endmodule

[sv/ybf_checker.sv]
// Port checker for the YMODEM block framer, bound to the top level.
`timescale 1ns / 1ps

module ybf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] first_octet,
  input logic [7:0] fourth_octet,
  input logic [2:0] octet_count,
  input logic       block_end,
  input logic       transfer_end,
  input logic [1:0] status,
  input logic       last_of_run
);
  import ybf_pkg::*;

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_octet) && $stable(octet_count)
      && $stable(last_of_run))
    else $error("output beat changed while stalled");

  // Only the last beat of a run may be short
  a_full_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> octet_count == 3'd4)
    else $error("short beat before end of run");

  // Flags appear only on the last beat of a run
  a_flags_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !block_end && !transfer_end && status == ST_OK)
    else $error("end flags on a middle beat");

  // Block limit ends the block and the transfer
  a_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_LIMIT |-> block_end && transfer_end && last_of_run)
    else $error("limit status without block and transfer end");

  // Idle data gives an empty beat
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_IDLE_DATA |-> octet_count == 3'd0 && fourth_octet == 8'h00)
    else $error("idle data beat carries bytes");

endmodule

bind ymodem_block_framer ybf_checker u_ybf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .first_octet  (first_octet),
  .fourth_octet (fourth_octet),
  .octet_count  (octet_count),
  .block_end    (block_end),
  .transfer_end (transfer_end),
  .status       (status),
  .last_of_run  (last_of_run)
);

[bench/tb_top.sv]
// Self-checking testbench for the YMODEM block framer: directed, boundary and random runs.
`timescale 1ns / 1ps

module tb_top;
  import ybf_pkg::*;

  localparam bit MODE_START = 1'b0;
  localparam bit MODE_DATA  = 1'b1;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_BEATS = 20;
  localparam int RANDOM_SIZE_MAX = 8;
  localparam int REPORT_MAX   = 10;
  localparam int MAX_WAIT     = 14;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] size;
    logic [7:0]        octet;
  } file_beat_t;

  typedef struct packed {
    logic [3:0][7:0] octets;   // octets[0] goes out first
    logic [2:0]      count;
    logic            blk_end;
    logic            xfer_end;
    logic [1:0]      stat;
    logic            last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic              mode       = MODE_START;
  logic [SIZE_W-1:0] file_size  = '0;
  logic [7:0]        data_octet = '0;
  logic              cfg_we     = 1'b0;
  logic              cfg_wdata  = 1'b1;
  logic              out_valid;
  logic              out_ready  = 1'b1;
  logic [7:0]        first_octet, second_octet, third_octet, fourth_octet;
  logic [2:0]        octet_count;
  logic              block_end, transfer_end, last_of_run;
  logic [1:0]        status;

  ymodem_block_framer uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .file_size    (file_size),
    .data_octet   (data_octet),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_octet  (first_octet),
    .second_octet (second_octet),
    .third_octet  (third_octet),
    .fourth_octet (fourth_octet),
    .octet_count  (octet_count),
    .block_end    (block_end),
    .transfer_end (transfer_end),
    .status       (status),
    .last_of_run  (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Framer shadow state
  bit                crc_on = 1'b1;
  logic [SIZE_W-1:0] bytes_left = '0;
  int unsigned       blk_fill = 0;
  bit                long_blk = 1'b0;
  logic [BN_W-1:0]   blk_num = BN_W'(1);
  logic [15:0]       crc_acc = '0;
  logic [7:0]        sum_acc = '0;
  bit                sending = 1'b0;
  bit                aborted = 1'b0;

  logic [7:0]  octet_stream[$];
  frame_word_t words_due[$];
  file_beat_t  pending[$];

  file_beat_t nxt;
  bit         calm = 1'b0;
  bit         in_taken = 1'b0;
  bit         out_taken = 1'b0;
  int         in_gap = 0;
  int         out_hold = 0;
  int         out_draw;

  int unsigned cycles = 0;
  int unsigned beats_issued = 0;
  int unsigned beats_taken = 0;
  int unsigned words_checked = 0;
  int unsigned blocks_closed = 0;
  int unsigned errors = 0;

  // CRC-16/XMODEM, one message bit at a time
  function automatic logic [15:0] crc_xmodem_next(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ 16'h1021;
    end
    return c;
  endfunction

  task automatic absorb_octet(input logic [7:0] b);
    crc_acc = crc_xmodem_next(crc_acc, b);
    sum_acc = sum_acc + b;
    octet_stream.push_back(b);
  endtask

  task automatic append_check();
    if (crc_on) begin
      octet_stream.push_back(crc_acc[15:8]);
      octet_stream.push_back(crc_acc[7:0]);
    end else begin
      octet_stream.push_back(sum_acc);
    end
  endtask

  // Split the byte stream of one beat into words of four
  task automatic pack_words(input logic be, input logic te, input logic [1:0] st);
    int groups;
    int r;
    int j;
    frame_word_t w;
    groups = (octet_stream.size() + 3) / 4;
    if (groups == 0) groups = 1;
    for (r = 0; r < groups; r++) begin
      w = '0;
      for (j = 0; j < 4; j++) begin
        if (r * 4 + j < octet_stream.size()) begin
          w.octets[j] = octet_stream[r * 4 + j];
          w.count = w.count + 3'd1;
        end
      end
      if (r == groups - 1) begin
        w.blk_end  = be;
        w.xfer_end = te;
        w.stat     = st;
        w.last     = 1'b1;
      end
      words_due.push_back(w);
    end
    octet_stream.delete();
  endtask

  // Expected words for one accepted beat
  task automatic predict_beat(input logic m, input logic [SIZE_W-1:0] sz, input logic [7:0] oc);
    int unsigned span;
    octet_stream.delete();
    if (m == MODE_START) begin
      bytes_left = sz;
      blk_fill   = 0;
      long_blk   = 1'b0;
      blk_num    = BN_W'(1);
      crc_acc    = '0;
      sum_acc    = '0;
      aborted    = 1'b0;
      sending    = (sz != 0);
      if (sz == 0) pack_words(1'b0, 1'b1, ST_OK);
      return;
    end
    if (!sending) begin
      pack_words(1'b0, 1'b0, ST_IDLE_DATA);
      return;
    end
    // Open a block: header decides long or short on what remains
    if (blk_fill == 0) begin
      long_blk = (bytes_left >= LONG_SIZE);
      crc_acc  = '0;
      sum_acc  = '0;
      octet_stream.push_back(long_blk ? STX_OCTET : SOH_OCTET);
      octet_stream.push_back(blk_num[7:0]);
      octet_stream.push_back(~blk_num[7:0]);
    end
    span = long_blk ? LONG_BLOCK : SHORT_BLOCK;
    absorb_octet(oc);
    bytes_left = bytes_left - 1'b1;
    blk_fill++;
    if (bytes_left == 0) begin
      // Pad out the final block and close the transfer
      while (blk_fill < span) begin
        absorb_octet(PAD_OCTET);
        blk_fill++;
      end
      append_check();
      blk_fill = 0;
      sending  = 1'b0;
      pack_words(1'b1, 1'b1, ST_OK);
    end else if (blk_fill >= span) begin
      append_check();
      blk_fill = 0;
      if (blk_num >= BN_LIMIT) begin
        aborted = 1'b1;
        sending = 1'b0;
        pack_words(1'b1, 1'b1, ST_LIMIT);
      end else begin
        blk_num = blk_num + 1'b1;
        pack_words(1'b1, 1'b0, ST_OK);
      end
    end else begin
      pack_words(1'b0, 1'b0, ST_OK);
    end
  endtask

  function automatic string word_text(input frame_word_t w);
    return $sformatf("%h %h %h %h cnt=%0d blk_end=%0d xfer_end=%0d status=%0d last=%0d",
                     w.octets[0], w.octets[1], w.octets[2], w.octets[3], w.count,
                     w.blk_end, w.xfer_end, w.stat, w.last);
  endfunction

  // Input driver: present the next beat once the current one is taken
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        mode       <= nxt.mode;
        file_size  <= nxt.size;
        data_octet <= nxt.octet;
        in_valid   <= 1'b1;
        in_gap     <= calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: after each taken word, draw a random hold and keep ready low while it counts down
  always @(negedge clk) begin
    if (out_taken) begin
      out_draw = calm ? 0 : $urandom_range(0, MAX_WAIT);
      out_hold  <= out_draw;
      out_ready <= (out_draw == 0);
    end else if (out_hold != 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= (out_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on accepted beats, check accepted words
  frame_word_t got, want;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycles, words_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    in_taken  <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst && in_valid && in_ready) begin
      beats_taken++;
      predict_beat(mode, file_size, data_octet);
    end
    if (!rst && out_valid && out_ready) begin
      got.octets   = {fourth_octet, third_octet, second_octet, first_octet};
      got.count    = octet_count;
      got.blk_end  = block_end;
      got.xfer_end = transfer_end;
      got.stat     = status;
      got.last     = last_of_run;
      words_checked++;
      if (words_due.size() == 0) begin
        if (errors < REPORT_MAX)
          $display("%0t: word with nothing expected: %s", $realtime, word_text(got));
        errors++;
      end else begin
        want = words_due.pop_front();
        if (want.blk_end) blocks_closed++;
        if (got.octets[0] !== want.octets[0] || got.octets[1] !== want.octets[1] ||
            got.octets[2] !== want.octets[2] || got.octets[3] !== want.octets[3] ||
            got.count !== want.count || got.blk_end !== want.blk_end ||
            got.xfer_end !== want.xfer_end || got.stat !== want.stat ||
            got.last !== want.last) begin
          if (errors < REPORT_MAX) begin
            $display("%0t: word mismatch", $realtime);
            $display("  expected %s", word_text(want));
            $display("  actual   %s", word_text(got));
          end
          errors++;
        end
      end
    end
  end

  // Stimulus helpers
  task automatic queue_beat(input logic m, input logic [SIZE_W-1:0] sz, input logic [7:0] oc);
    file_beat_t b;
    while (pending.size() > 64) @(negedge clk);
    b.mode  = m;
    b.size  = sz;
    b.octet = oc;
    pending.push_back(b);
    beats_issued++;
  endtask

  task automatic queue_start(input int unsigned sz);
    queue_beat(MODE_START, SIZE_W'(sz), 8'($urandom));
  endtask

  task automatic queue_data(input logic [7:0] oc);
    queue_beat(MODE_DATA, SIZE_W'($urandom), oc);
  endtask

  task automatic send_file(input int unsigned sz, input int unsigned fed);
    queue_start(sz);
    repeat (fed) queue_data(8'($urandom));
  endtask

  // Wait until every beat is taken and every word checked, then let the block settle
  task automatic settle();
    do @(negedge clk);
    while (beats_taken != beats_issued || words_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_crc_mode(input bit on);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    crc_on = on;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(input int unsigned quota);
    int unsigned done_beats;
    int unsigned pick;
    int unsigned size;
    int unsigned fed;
    done_beats = 0;
    while (done_beats < quota) begin
      if ($urandom_range(0, 24) == 0) calm = ~calm;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_data(8'($urandom));
        done_beats++;
      end else if (pick == 1) begin
        queue_start(0);
        done_beats++;
      end else begin
        size = $urandom_range(1, RANDOM_SIZE_MAX);
        // Mostly whole files; a few are cut short and dropped by the next start
        fed = (pick == 2) ? $urandom_range(0, size - 1) : size;
        send_file(size, fed);
        done_beats += fed + 1;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: idle data, empty file, tiny file, restarts, widest size
    queue_data(8'hFF);
    queue_start(0);
    queue_start(3);
    queue_data(8'h00);
    queue_data(8'hFF);
    queue_data(8'h55);
    queue_data(8'hA5);
    queue_start(5);
    queue_data(8'h12);
    queue_data(8'h34);
    queue_start(1);
    queue_data(8'h80);
    queue_start((1 << SIZE_W) - 1);
    queue_data(8'h01);
    queue_data(8'hFE);
    queue_start(0);
    settle();

    // Checksum mode: tiny file, then short random files
    write_crc_mode(1'b0);
    queue_start(2);
    queue_data(8'h00);
    queue_data(8'hFF);
    random_traffic(RANDOM_BEATS / 2);
    settle();

    // CRC mode: one full short block plus one byte, then short random files
    write_crc_mode(1'b1);
    send_file(SHORT_BLOCK + 1, SHORT_BLOCK + 1);
    random_traffic(RANDOM_BEATS - RANDOM_BEATS / 2);
    settle();
    calm = 1'b0;

    repeat (40) @(negedge clk);
    $display("Ran %0d input beats and checked %0d output words over %0d cycles",
             beats_taken, words_checked, cycles);
    $display("Closed %0d blocks in CRC and checksum modes, %0d errors",
             blocks_closed, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ybf_pkg.sv
sv/ybf_datapath.sv
sv/ybf_ctrl.sv
sv/ymodem_block_framer.sv
sv/ybf_checker.sv
bench/tb_top.sv
